// ===== sv/ilist_pkg.sv =====
// Package: list engine constants, request and status codes.
package ilist_pkg;

   localparam int DEPTH  = 256;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = ADDR_W + 1;

   localparam logic [2:0] REQ_PUSH   = 3'd0;
   localparam logic [2:0] REQ_POP    = 3'd1;
   localparam logic [2:0] REQ_INSERT = 3'd2;
   localparam logic [2:0] REQ_ERASE  = 3'd3;
   localparam logic [2:0] REQ_FIND   = 3'd4;
   localparam logic [2:0] REQ_READ   = 3'd5;
   localparam logic [2:0] REQ_SORT   = 3'd6;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

endpackage

// ===== sv/indexed_list_engine.sv =====
// Top level: ordered word list kept in one synchronous RAM.
//
//   channel | direction | handshake          | words
//   req_    | in        | req_valid/req_stall | req_type, req_item_value, req_position
//   rsp_    | out       | rsp_valid/rsp_stall | status, read_value, found, position, count
//
// Push, invalid codes, requests that fail their range, full or empty check, and find or sort on
// an empty list finish in the accept cycle. Pop and read do one RAM read. Insert and erase shift
// the words past the position one by one and find reads words in order until a match, all bound
// by the single RAM read port. Sort runs bubble passes until a pass swaps nothing, up to count
// passes. Reset (synchronous) empties the list; RAM contents are not cleared.
// A stalled result waits in the output register; the next request is taken
// once that register drains.
module indexed_list_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_type,
   input  logic signed [31:0] req_item_value,
   input  logic [8:0]         req_position,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_read_value,
   output logic               rsp_found,
   output logic [7:0]         rsp_found_position,
   output logic [8:0]         rsp_entry_count
);

   localparam int AW = ilist_pkg::ADDR_W;
   localparam int CW = ilist_pkg::CNT_W;
   localparam logic [CW-1:0] FULL_CNT = CW'(ilist_pkg::DEPTH);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOP = 2'd1;
   localparam logic [1:0] S_DATA = 2'd2;

   // word storage
   logic [31:0] mem [ilist_pkg::DEPTH];
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [31:0]   mem_wd;
   logic [AW-1:0] mem_ra;
   logic [31:0]   rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= mem[mem_ra];
   end

   logic [1:0]    state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [31:0]   held_ff, held_in;
   logic          swap_ff, swap_in;

   logic          rv_ff, rv_in;
   logic [1:0]    rst_ff, rst_in;
   logic [31:0]   rrd_ff, rrd_in;
   logic          rfnd_ff, rfnd_in;
   logic [7:0]    rfpos_ff, rfpos_in;
   logic [8:0]    rcnt_ff, rcnt_in;

   logic accept;
   logic out_free;

   assign out_free  = !rv_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      held_in  = held_ff;
      swap_in  = swap_ff;
      rv_in    = rv_ff && rsp_stall;
      rst_in   = rst_ff;
      rrd_in   = rrd_ff;
      rfnd_in  = rfnd_ff;
      rfpos_in = rfpos_ff;
      rcnt_in  = rcnt_ff;
      mem_we   = 1'b0;
      mem_wa   = idx_ff[AW-1:0];
      mem_wd   = held_ff;
      mem_ra   = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_type;
               held_in  = req_item_value;
               swap_in  = 1'b0;
               // default result: ok, count unchanged; overwritten below
               rv_in    = 1'b1;
               rst_in   = ilist_pkg::ST_OK;
               rrd_in   = '0;
               rfnd_in  = 1'b0;
               rfpos_in = '0;
               rcnt_in  = 9'(count_ff);
               case (req_type)
                  ilist_pkg::REQ_PUSH: begin
                     if (count_ff == FULL_CNT) begin
                        rst_in = ilist_pkg::ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        mem_wa   = count_ff[AW-1:0];
                        mem_wd   = req_item_value;
                        count_in = count_ff + 1'b1;
                        rcnt_in  = 9'(count_ff + 1'b1);
                     end
                  end
                  ilist_pkg::REQ_POP: begin
                     if (count_ff == '0) begin
                        rst_in = ilist_pkg::ST_EMPTY;
                     end else begin
                        // read the last word, answer once it returns
                        rv_in    = 1'b0;
                        mem_ra   = AW'(count_ff - 1'b1);
                        count_in = count_ff - 1'b1;
                        rcnt_in  = 9'(count_ff - 1'b1);
                        state_in = S_DATA;
                     end
                  end
                  ilist_pkg::REQ_READ: begin
                     if (CW'(req_position) >= count_ff) begin
                        rst_in = ilist_pkg::ST_RANGE;
                     end else begin
                        rv_in    = 1'b0;
                        mem_ra   = req_position[AW-1:0];
                        state_in = S_DATA;
                     end
                  end
                  ilist_pkg::REQ_INSERT: begin
                     if (count_ff == FULL_CNT) begin
                        rst_in = ilist_pkg::ST_FULL;
                     end else if (CW'(req_position) >= count_ff) begin
                        mem_we   = 1'b1;
                        mem_wa   = count_ff[AW-1:0];
                        mem_wd   = req_item_value;
                        count_in = count_ff + 1'b1;
                        rcnt_in  = 9'(count_ff + 1'b1);
                        rst_in   = ilist_pkg::ST_RANGE;
                     end else begin
                        rv_in    = 1'b0;
                        idx_in   = CW'(req_position);
                        state_in = S_LOOP;
                     end
                  end
                  ilist_pkg::REQ_ERASE: begin
                     if (CW'(req_position) >= count_ff) begin
                        rst_in = ilist_pkg::ST_RANGE;
                     end else begin
                        rv_in    = 1'b0;
                        idx_in   = CW'(req_position) + 1'b1;
                        state_in = S_LOOP;
                     end
                  end
                  ilist_pkg::REQ_FIND,
                  ilist_pkg::REQ_SORT: begin
                     if (count_ff != '0) begin
                        rv_in    = 1'b0;
                        idx_in   = '0;
                        state_in = S_LOOP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_LOOP: begin
            if (idx_ff == count_ff) begin
               // end of a sweep over the list
               case (op_ff)
                  ilist_pkg::REQ_INSERT: begin
                     mem_we   = 1'b1;
                     mem_wa   = idx_ff[AW-1:0];
                     mem_wd   = held_ff;
                     count_in = count_ff + 1'b1;
                     rcnt_in  = 9'(count_ff + 1'b1);
                     rv_in    = 1'b1;
                     state_in = S_IDLE;
                  end
                  ilist_pkg::REQ_ERASE: begin
                     count_in = count_ff - 1'b1;
                     rcnt_in  = 9'(count_ff - 1'b1);
                     rv_in    = 1'b1;
                     state_in = S_IDLE;
                  end
                  ilist_pkg::REQ_SORT: begin
                     // drop the carried word into the last slot
                     mem_we = 1'b1;
                     mem_wa = AW'(idx_ff - 1'b1);
                     mem_wd = held_ff;
                     if (swap_ff) begin
                        swap_in = 1'b0;
                        idx_in  = '0;
                     end else begin
                        rv_in    = 1'b1;
                        state_in = S_IDLE;
                     end
                  end
                  default: begin
                     // find without a match
                     rv_in    = 1'b1;
                     state_in = S_IDLE;
                  end
               endcase
            end else begin
               mem_ra   = idx_ff[AW-1:0];
               state_in = S_DATA;
            end
         end

         S_DATA: begin
            state_in = S_LOOP;
            idx_in   = idx_ff + 1'b1;
            case (op_ff)
               ilist_pkg::REQ_POP,
               ilist_pkg::REQ_READ: begin
                  rrd_in   = rdata_ff;
                  rv_in    = 1'b1;
                  state_in = S_IDLE;
               end
               ilist_pkg::REQ_INSERT: begin
                  // shift up: store carried word, carry the displaced one
                  mem_we  = 1'b1;
                  mem_wa  = idx_ff[AW-1:0];
                  mem_wd  = held_ff;
                  held_in = rdata_ff;
               end
               ilist_pkg::REQ_ERASE: begin
                  mem_we = 1'b1;
                  mem_wa = AW'(idx_ff - 1'b1);
                  mem_wd = rdata_ff;
               end
               ilist_pkg::REQ_FIND: begin
                  if (rdata_ff == held_ff) begin
                     rfnd_in  = 1'b1;
                     rfpos_in = 8'(idx_ff);
                     rv_in    = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  // sort: bubble the larger word forward
                  if (idx_ff == '0) begin
                     held_in = rdata_ff;
                  end else if ($signed(held_ff) > $signed(rdata_ff)) begin
                     mem_we  = 1'b1;
                     mem_wa  = AW'(idx_ff - 1'b1);
                     mem_wd  = rdata_ff;
                     swap_in = 1'b1;
                  end else begin
                     mem_we  = 1'b1;
                     mem_wa  = AW'(idx_ff - 1'b1);
                     mem_wd  = held_ff;
                     held_in = rdata_ff;
                  end
               end
            endcase
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
      op_ff    <= op_in;
      idx_ff   <= idx_in;
      held_ff  <= held_in;
      swap_ff  <= swap_in;
      rst_ff   <= rst_in;
      rrd_ff   <= rrd_in;
      rfnd_ff  <= rfnd_in;
      rfpos_ff <= rfpos_in;
      rcnt_ff  <= rcnt_in;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_status         = rst_ff;
   assign rsp_read_value     = rrd_ff;
   assign rsp_found          = rfnd_ff;
   assign rsp_found_position = rfpos_ff;
   assign rsp_entry_count    = rcnt_ff;

endmodule

// ===== bench/list_checker.sv =====
// Checker: watches both channels, predicts the list engine's results and compares them.
module list_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_type,
   input  logic signed [31:0] req_item_value,
   input  logic [8:0]         req_position,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_status,
   input  logic signed [31:0] rsp_read_value,
   input  logic               rsp_found,
   input  logic [7:0]         rsp_found_position,
   input  logic [8:0]         rsp_entry_count,
   output int                 fail_count,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] read_value;
      logic               found;
      logic [7:0]         found_position;
      logic [8:0]         entry_count;
   } list_result_type;

   logic signed [31:0] shadow_list [ilist_pkg::DEPTH];
   int                 shadow_count;
   list_result_type    result_queue [$];

   // Compute one result and update the shadow list.
   function automatic list_result_type apply_request(logic [2:0] op,
                                                     logic signed [31:0] word,
                                                     logic [8:0] pos);
      list_result_type r;
      logic signed [31:0] key;
      int j;
      r = '0;
      case (op)
         ilist_pkg::REQ_PUSH: begin
            if (shadow_count >= ilist_pkg::DEPTH) r.status = ilist_pkg::ST_FULL;
            else begin
               shadow_list[shadow_count] = word;
               shadow_count++;
            end
         end
         ilist_pkg::REQ_POP: begin
            if (shadow_count == 0) r.status = ilist_pkg::ST_EMPTY;
            else begin
               shadow_count--;
               r.read_value = shadow_list[shadow_count];
            end
         end
         ilist_pkg::REQ_INSERT: begin
            if (shadow_count >= ilist_pkg::DEPTH) r.status = ilist_pkg::ST_FULL;
            else if (pos < shadow_count) begin
               for (int i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[pos] = word;
               shadow_count++;
            end else begin
               shadow_list[shadow_count] = word;
               shadow_count++;
               r.status = ilist_pkg::ST_RANGE;
            end
         end
         ilist_pkg::REQ_ERASE: begin
            if (pos < shadow_count) begin
               shadow_count--;
               for (int i = pos; i < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
            end else r.status = ilist_pkg::ST_RANGE;
         end
         ilist_pkg::REQ_FIND: begin
            for (int i = 0; i < shadow_count; i++) begin
               if (!r.found && shadow_list[i] == word) begin
                  r.found = 1'b1;
                  r.found_position = i[7:0];
               end
            end
         end
         ilist_pkg::REQ_READ: begin
            if (pos < shadow_count) r.read_value = shadow_list[pos];
            else r.status = ilist_pkg::ST_RANGE;
         end
         ilist_pkg::REQ_SORT: begin
            for (int i = 1; i < shadow_count; i++) begin
               key = shadow_list[i];
               j = i;
               while (j > 0 && key < shadow_list[j-1]) begin
                  shadow_list[j] = shadow_list[j-1];
                  j--;
               end
               shadow_list[j] = key;
            end
         end
         default: ;
      endcase
      r.entry_count = shadow_count[8:0];
      return r;
   endfunction

   always @(posedge clock) begin
      list_result_type want;
      list_result_type got;
      if (reset) begin
         shadow_count = 0;
         result_queue.delete();
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall)
            result_queue.insert(result_queue.size(),
                                apply_request(req_type, req_item_value, req_position));
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_read_value, rsp_found, rsp_found_position,
                   rsp_entry_count};
            if (result_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result word %h at %0t", got, $realtime);
            end else begin
               want = result_queue.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"mismatch at %0t (expected/actual): status %0d/%0d ",
                               "value %0d/%0d found %0d/%0d pos %0d/%0d count %0d/%0d"},
                              $realtime, want.status, got.status, want.read_value,
                              got.read_value, want.found, got.found, want.found_position,
                              got.found_position, want.entry_count, got.entry_count);
               end
            end
         end
      end
      pending = result_queue.size();
   end
endmodule

// ===== bench/testbench.sv =====
// Testbench top: drives requests into the list engine and gives the verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] REQ_UNUSED = 3'd7;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_type;
   logic signed [31:0] req_item_value;
   logic [8:0]         req_position;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_read_value;
   logic               rsp_found;
   logic [7:0]         rsp_found_position;
   logic [8:0]         rsp_entry_count;
   int                 fail_count;
   int                 pending;

   // Idle percentages for each side; the receiver process and send_word read these.
   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles;     // long receiver hold-off requested by stimulus
   int model_count;     // rough count tracked here to steer stimulus

   indexed_list_engine dut (.*);

   list_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Generous limit: sort alone may run one bubble pass per stored word.
   initial begin
      #400ms;
      $display("FAIL");
      $finish;
   end

   // Receiver: random stall, plus a long hold-off when asked.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Offer one word and hold it until accepted; optionally idle first.
   // Valid stays high after acceptance until the next idle or drain.
   task automatic send_word(logic [2:0] op, logic signed [31:0] word, logic [8:0] pos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= op;
      req_item_value <= word;
      req_position   <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      // Track count so the random mix steers toward full and empty.
      case (op)
         ilist_pkg::REQ_PUSH:   if (model_count < ilist_pkg::DEPTH) model_count++;
         ilist_pkg::REQ_INSERT: if (model_count < ilist_pkg::DEPTH) model_count++;
         ilist_pkg::REQ_POP:    if (model_count > 0) model_count--;
         ilist_pkg::REQ_ERASE:  if (pos < model_count) model_count--;
         default: ;
      endcase
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Pick a word: extremes, small values (so finds hit) or fully random.
   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return $urandom_range(7) - 3;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(int n_items, int bias_fill);
      logic [2:0] op;
      logic [8:0] pos;
      int roll;
      for (int i = 0; i < n_items; i++) begin
         roll = $urandom_range(99);
         if (roll < bias_fill) op = ilist_pkg::REQ_PUSH;
         else if (roll < 96) op = 3'($urandom_range(5));
         else if (roll < 99) op = ilist_pkg::REQ_SORT;
         else op = REQ_UNUSED;
         // Mostly in-range positions, some beyond count.
         if ($urandom_range(3) == 0 || model_count == 0) pos = 9'($urandom);
         else pos = 9'($urandom_range(model_count - 1));
         send_word(op, pick_word(), pos);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = ilist_pkg::REQ_PUSH;
      req_item_value = '0;
      req_position = '0;
      rsp_stall = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 0;
      model_count = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty-list cases, extremes, every operation.
      send_word(ilist_pkg::REQ_POP, 0, 0);
      send_word(ilist_pkg::REQ_FIND, 5, 0);
      send_word(ilist_pkg::REQ_SORT, 0, 0);
      send_word(ilist_pkg::REQ_READ, 0, 0);
      send_word(ilist_pkg::REQ_ERASE, 0, 0);
      send_word(ilist_pkg::REQ_PUSH, 32'sh7fff_ffff, 0);
      send_word(ilist_pkg::REQ_PUSH, 32'sh8000_0000, 0);
      send_word(ilist_pkg::REQ_INSERT, -1, 0);
      send_word(ilist_pkg::REQ_INSERT, 7, 9'h1ff);
      send_word(ilist_pkg::REQ_READ, 0, 1);
      send_word(ilist_pkg::REQ_READ, 0, 9'h1ff);
      send_word(ilist_pkg::REQ_FIND, 7, 0);
      send_word(ilist_pkg::REQ_FIND, 123, 0);
      send_word(ilist_pkg::REQ_SORT, 0, 0);
      send_word(ilist_pkg::REQ_ERASE, 0, 1);
      send_word(ilist_pkg::REQ_ERASE, 0, 9'h100);
      send_word(REQ_UNUSED, 32'shffff_ffff, 9'h1ff);
      send_word(ilist_pkg::REQ_POP, 0, 0);
      drain();

      // Fill to full and poke the full cases, with a long receiver hold-off.
      hold_cycles <= 300;
      while (model_count < ilist_pkg::DEPTH) send_word(ilist_pkg::REQ_PUSH, pick_word(), 0);
      send_word(ilist_pkg::REQ_PUSH, 1, 0);
      send_word(ilist_pkg::REQ_INSERT, 2, 0);
      send_word(ilist_pkg::REQ_FIND, 32'sh8000_0000, 0);
      send_word(ilist_pkg::REQ_SORT, 0, 0);
      send_word(ilist_pkg::REQ_READ, 0, 255);
      drain();
      while (model_count > 0) send_word(ilist_pkg::REQ_POP, 0, 0);
      drain();

      // Random phases: receiver-heavy idle, sender-heavy idle, none.
      send_idle_pct = 31; recv_idle_pct = 50;
      random_phase(190, 20);
      drain();
      send_idle_pct = 50; recv_idle_pct = 31;
      random_phase(190, 15);
      drain();
      send_idle_pct = 0; recv_idle_pct = 0;
      random_phase(190, 20);
      drain();

      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
